// ===== sv/bmc_pkg.sv =====
// Shared types, command words and constants of the balance motor controller.
package bmc_pkg;

    localparam int DIV_N  = 27;
    localparam int DIV_D  = 17;
    localparam int CNT_W  = $clog2(DIV_N + 1);
    localparam int MUL_A  = 24;
    localparam int MUL_B  = 21;
    localparam int PROD_W = MUL_A + MUL_B;
    localparam int ACC_W  = 48;
    localparam int TERM_W = 34;
    localparam int MUL_STEPS = 5;
    localparam int CFG_W  = 21;
    localparam int IDX_W  = 3;

    // filter divide by ten: x * ceil(2^30 / 10) >> 30, exact for x below 2^27
    localparam int FILT_W     = 27;
    localparam int FILT_P_W   = 2 * FILT_W;
    localparam int FILT_SHIFT = 30;

    localparam logic signed [16:0] TILT_LIMIT     = 17'sd10240;
    localparam logic signed [25:0] INTEGRAL_LIMIT = 26'sd640000;
    localparam logic [9:0]         STEP_MIN       = 10'd154;
    localparam logic [9:0]         STEP_MAX       = 10'd768;
    localparam logic [9:0]         STEP_IDLE      = 10'd230;
    localparam logic [DIV_N-1:0]   FWD_SPEED      = DIV_N'(300);
    localparam logic [DIV_N-1:0]   BWD_SPEED      = DIV_N'(250);
    localparam logic [DIV_N-1:0]   TURN_AMP       = DIV_N'(150);
    localparam logic [DIV_N-1:0]   STEP_NUM       = DIV_N'(12800);
    localparam logic [FILT_W-1:0]  FILT_RECIP     = FILT_W'(107374183);

    localparam logic signed [14:0] MID_ANGLE_RST   = 15'sd256;
    localparam logic signed [20:0] BALANCE_KP_RST  = 21'sd140800;
    localparam logic signed [20:0] BALANCE_KD_RST  = 21'sd384;
    localparam logic signed [20:0] VELOCITY_KP_RST = -21'sd30720;
    localparam logic signed [20:0] VELOCITY_KI_RST = -21'sd154;
    localparam logic signed [20:0] TURN_KP_RST     = 21'sd10752;
    localparam logic [7:0]         SPEED_DIV_RST   = 8'd1;
    localparam logic [12:0]        PWM_LIMIT_RST   = 13'd7100;

    typedef enum logic [IDX_W-1:0] {
        CR_MID_ANGLE   = 3'd0,
        CR_BALANCE_KP  = 3'd1,
        CR_BALANCE_KD  = 3'd2,
        CR_VELOCITY_KP = 3'd3,
        CR_VELOCITY_KI = 3'd4,
        CR_TURN_KP     = 3'd5,
        CR_SPEED_DIV   = 3'd6,
        CR_PWM_LIMIT   = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DS_MOVE = 2'd1,
        DS_AMP  = 2'd2,
        DS_STEP = 2'd3
    } div_sel_t;

    typedef enum logic [2:0] {
        MS_BKP = 3'd0,
        MS_BKD = 3'd1,
        MS_VKP = 3'd2,
        MS_VKI = 3'd3,
        MS_TKP = 3'd4
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     filt_abs;
        logic     filt_mul;
        logic     filt_store;
        logic     div_start;
        logic     div_store;
        div_sel_t div_sel;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        mul_sel_t acc_sel;
        logic     upd;
        logic     fin;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

endpackage

// ===== sv/bmc_if.sv =====
// Input and result word channels.
interface bmc_in_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] tilt_angle;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic               go_forward;
    logic               go_backward;
    logic               go_left;
    logic               go_right;
    logic               stop_request;

    modport source (output valid, tilt_angle, pitch_rate, yaw_rate, left_count, right_count,
                    go_forward, go_backward, go_left, go_right, stop_request,
                    input ready);
    modport sink (input valid, tilt_angle, pitch_rate, yaw_rate, left_count, right_count,
                  go_forward, go_backward, go_left, go_right, stop_request,
                  output ready);
endinterface

interface bmc_out_if;
    logic               valid;
    logic               ready;
    logic signed [13:0] motor_a_drive;
    logic signed [13:0] motor_b_drive;
    logic               motors_enabled;

    modport source (output valid, motor_a_drive, motor_b_drive, motors_enabled, input ready);
    modport sink (input valid, motor_a_drive, motor_b_drive, motors_enabled, output ready);
endinterface

// ===== sv/bmc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module bmc_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [bmc_pkg::DIV_N-1:0]  dividend,
    input  logic [bmc_pkg::DIV_D-1:0]  divisor,
    output logic [bmc_pkg::DIV_N-1:0]  quotient,
    output logic                       done
);
    import bmc_pkg::*;

    logic [DIV_D-1:0] rem_reg;
    logic [DIV_N-1:0] quo_reg;
    logic [DIV_D-1:0] dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_D:0]   trial;
    logic             ge;
    logic [DIV_D:0]   rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_N-1]};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = ge ? trial - {1'b0, dsr_reg} : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next[DIV_D-1:0];
            quo_reg <= {quo_reg[DIV_N-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== sv/bmc_dp.sv =====
// Datapath: configuration, loop state, shared multiplier and divider, mixing.
module bmc_dp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bmc_pkg::IDX_W-1:0] cfg_index,
    input  logic [bmc_pkg::CFG_W-1:0] cfg_data,
    input  logic signed [16:0]        tilt_angle,
    input  logic signed [15:0]        pitch_rate,
    input  logic signed [15:0]        yaw_rate,
    input  logic signed [15:0]        left_count,
    input  logic signed [15:0]        right_count,
    input  logic                      go_forward,
    input  logic                      go_backward,
    input  logic                      go_left,
    input  logic                      go_right,
    input  logic                      stop_request,
    input  bmc_pkg::dp_cmd_t          cmd,
    output bmc_pkg::dp_status_t       status,
    output logic signed [13:0]        motor_a_drive,
    output logic signed [13:0]        motor_b_drive,
    output logic                      motors_enabled
);
    import bmc_pkg::*;

    logic signed [14:0] mid_reg;
    logic signed [20:0] bkp_reg, bkd_reg, vkp_reg, vki_reg, tkp_reg;
    logic [7:0]         div_reg;
    logic [12:0]        lim_reg;

    logic signed [16:0] tilt_reg;
    logic signed [15:0] pr_reg, yr_reg;
    logic signed [16:0] sum_reg;
    logic fwd_reg, bwd_reg, lft_reg, rgt_reg, off_reg;

    logic signed [23:0] f_reg, integral_reg;
    logic signed [19:0] tt_reg;
    logic [16:0]        tss_reg;
    logic               ta_reg;
    logic signed [9:0]  move_reg;
    logic [7:0]         amp_reg;
    logic [9:0]         step_reg;

    logic [FILT_W-1:0]   fabs_reg;
    logic                fneg_reg;
    logic [FILT_P_W-1:0] fprod_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [TERM_W-1:0] bal_reg, vel_reg, trn_reg;
    logic signed [13:0]       ma_reg, mb_reg;
    logic                     en_reg;

    logic signed [16:0]  sum_in;
    logic                off_in;
    logic [7:0]          div_eff;
    logic signed [28:0]  num, f9;
    logic [28:0]         num_abs;
    logic [23:0]         fquo;
    logic [DIV_N-1:0]    dividend, quotient;
    logic [DIV_D-1:0]    divisor;
    logic                div_done;
    logic [9:0]          step_next;
    logic signed [25:0]  isum;
    logic signed [23:0]  integral_next;
    logic signed [20:0]  tsum, amp_q8;
    logic signed [19:0]  tt_next;
    logic signed [MUL_A-1:0] mul_a;
    logic signed [MUL_B-1:0] mul_b;
    logic signed [ACC_W-1:0] prod_x, acc_sum;
    logic signed [35:0]  mix_t, m1, m2, lim_x;
    logic signed [13:0]  ma_next, mb_next;

    function automatic logic signed [TERM_W-1:0] tz_shift(input logic signed [ACC_W-1:0] x,
                                                         input int sh);
        logic signed [ACC_W-1:0] bias;
        logic signed [ACC_W-1:0] y;
        bias = ({{(ACC_W-1){1'b0}}, 1'b1} <<< sh) - 1'b1;
        y    = x[ACC_W-1] ? x + bias : x;
        y    = y >>> sh;
        return y[TERM_W-1:0];
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= MID_ANGLE_RST;
            bkp_reg <= BALANCE_KP_RST;
            bkd_reg <= BALANCE_KD_RST;
            vkp_reg <= VELOCITY_KP_RST;
            vki_reg <= VELOCITY_KI_RST;
            tkp_reg <= TURN_KP_RST;
            div_reg <= SPEED_DIV_RST;
            lim_reg <= PWM_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CR_MID_ANGLE:   mid_reg <= cfg_data[14:0];
                CR_BALANCE_KP:  bkp_reg <= cfg_data;
                CR_BALANCE_KD:  bkd_reg <= cfg_data;
                CR_VELOCITY_KP: vkp_reg <= cfg_data;
                CR_VELOCITY_KI: vki_reg <= cfg_data;
                CR_TURN_KP:     tkp_reg <= cfg_data;
                CR_SPEED_DIV:   div_reg <= cfg_data[7:0];
                CR_PWM_LIMIT:   lim_reg <= cfg_data[12:0];
            endcase
        end
    end

    always_comb
    begin
        sum_in  = {left_count[15], left_count} + {right_count[15], right_count};
        off_in  = (tilt_angle < -TILT_LIMIT) || (tilt_angle > TILT_LIMIT) || stop_request;
        div_eff = (div_reg == 8'd0) ? 8'd1 : div_reg;

        f9      = ({{5{f_reg[23]}}, f_reg} <<< 3) + {{5{f_reg[23]}}, f_reg};
        num     = {{6{sum_reg[16]}}, sum_reg, 6'b0} + f9;
        num_abs = num[28] ? 29'(-num) : 29'(num);
        fquo    = fprod_reg[FILT_SHIFT+23:FILT_SHIFT];

        case (cmd.div_sel)
            DS_MOVE:
            begin
                dividend = fwd_reg ? FWD_SPEED : BWD_SPEED;
                divisor  = {{(DIV_D-8){1'b0}}, div_eff};
            end
            DS_AMP:
            begin
                dividend = TURN_AMP;
                divisor  = {{(DIV_D-8){1'b0}}, div_eff};
            end
            default:
            begin
                dividend = STEP_NUM;
                divisor  = tss_reg;
            end
        endcase

        if (!(lft_reg || rgt_reg))
            step_next = STEP_IDLE;
        else if (tss_reg == 17'd0 || quotient > DIV_N'(STEP_MAX))
            step_next = STEP_MAX;
        else if (quotient < DIV_N'(STEP_MIN))
            step_next = STEP_MIN;
        else
            step_next = quotient[9:0];

        isum = {{2{integral_reg[23]}}, integral_reg} + {{2{f_reg[23]}}, f_reg}
             - {{10{move_reg[9]}}, move_reg, 6'b0};
        if (isum > INTEGRAL_LIMIT)
            integral_next = INTEGRAL_LIMIT[23:0];
        else if (isum < -INTEGRAL_LIMIT)
            integral_next = 24'(-INTEGRAL_LIMIT);
        else
            integral_next = isum[23:0];

        amp_q8 = {5'b0, amp_reg, 8'b0};
        if (lft_reg)
            tsum = {tt_reg[19], tt_reg} - {11'b0, step_reg};
        else if (rgt_reg)
            tsum = {tt_reg[19], tt_reg} + {11'b0, step_reg};
        else
            tsum = '0;
        if (tsum > amp_q8)
            tt_next = amp_q8[19:0];
        else if (tsum < -amp_q8)
            tt_next = 20'(-amp_q8);
        else
            tt_next = tsum[19:0];

        case (cmd.mul_sel)
            MS_BKP:
            begin
                mul_a = {{7{tilt_reg[16]}}, tilt_reg} - {{9{mid_reg[14]}}, mid_reg};
                mul_b = bkp_reg;
            end
            MS_BKD:
            begin
                mul_a = {{8{pr_reg[15]}}, pr_reg};
                mul_b = bkd_reg;
            end
            MS_VKP:
            begin
                mul_a = f_reg;
                mul_b = vkp_reg;
            end
            MS_VKI:
            begin
                mul_a = integral_reg;
                mul_b = vki_reg;
            end
            default:
            begin
                mul_a = {{4{tt_reg[19]}}, tt_reg};
                mul_b = tkp_reg;
            end
        endcase

        prod_x = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        case (cmd.acc_sel)
            MS_BKD:  acc_sum = acc_reg + (prod_x <<< 8);
            MS_VKI:  acc_sum = acc_reg + prod_x;
            MS_TKP:  acc_sum = -prod_x - ((fwd_reg || bwd_reg)
                               ? {{16{yr_reg[15]}}, yr_reg, 16'b0} : '0);
            default: acc_sum = prod_x;
        endcase

        lim_x = {23'b0, lim_reg};
        mix_t = {{2{bal_reg[TERM_W-1]}}, bal_reg} - {{2{vel_reg[TERM_W-1]}}, vel_reg};
        m1    = mix_t - {{2{trn_reg[TERM_W-1]}}, trn_reg};
        m2    = mix_t + {{2{trn_reg[TERM_W-1]}}, trn_reg};
        if (m1 > lim_x)
            ma_next = lim_x[13:0];
        else if (m1 < -lim_x)
            ma_next = 14'(-lim_x);
        else
            ma_next = m1[13:0];
        if (m2 > lim_x)
            mb_next = lim_x[13:0];
        else if (m2 < -lim_x)
            mb_next = 14'(-lim_x);
        else
            mb_next = m2[13:0];
    end

    bmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .quotient (quotient),
        .done     (div_done)
    );

    assign status.div_done = div_done;

    // loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_reg        <= '0;
            integral_reg <= '0;
            tt_reg       <= '0;
            tss_reg      <= '0;
            ta_reg       <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (go_left || go_right)
                begin
                    if (!ta_reg)
                    begin
                        ta_reg  <= 1'b1;
                        tss_reg <= sum_in[16] ? 17'(-sum_in) : 17'(sum_in);
                    end
                end
                else
                begin
                    ta_reg  <= 1'b0;
                    tss_reg <= '0;
                end
            end
            if (cmd.filt_store)
                f_reg <= fneg_reg ? 24'(-fquo) : fquo;
            if (cmd.upd)
            begin
                integral_reg <= integral_next;
                tt_reg       <= tt_next;
            end
            if (cmd.fin && off_reg)
                integral_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tilt_reg <= tilt_angle;
            pr_reg   <= pitch_rate;
            yr_reg   <= yaw_rate;
            sum_reg  <= sum_in;
            fwd_reg  <= go_forward;
            bwd_reg  <= go_backward;
            lft_reg  <= go_left;
            rgt_reg  <= go_right;
            off_reg  <= off_in;
        end
        if (cmd.filt_abs)
        begin
            fabs_reg <= num_abs[FILT_W-1:0];
            fneg_reg <= num[28];
        end
        if (cmd.filt_mul)
            fprod_reg <= fabs_reg * FILT_RECIP;
        if (cmd.div_store && div_done)
        begin
            case (cmd.div_sel)
                DS_MOVE:
                    move_reg <= fwd_reg ? $signed({1'b0, quotient[8:0]})
                              : bwd_reg ? -$signed({1'b0, quotient[8:0]}) : 10'sd0;
                DS_AMP:  amp_reg  <= quotient[7:0];
                DS_STEP: step_reg <= step_next;
                default: ;
            endcase
        end
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        if (cmd.acc_en)
        begin
            case (cmd.acc_sel)
                MS_BKD:  bal_reg <= tz_shift(acc_sum, 16);
                MS_VKI:  vel_reg <= tz_shift(acc_sum, 14);
                MS_TKP:  trn_reg <= tz_shift(acc_sum, 16);
                default: acc_reg <= acc_sum;
            endcase
        end
        if (cmd.fin)
        begin
            ma_reg <= off_reg ? 14'sd0 : ma_next;
            mb_reg <= off_reg ? 14'sd0 : mb_next;
            en_reg <= !off_reg;
        end
    end

    assign motor_a_drive  = ma_reg;
    assign motor_b_drive  = mb_reg;
    assign motors_enabled = en_reg;

endmodule

// ===== sv/bmc_ctrl.sv =====
// Controller state machine: sequences the filter steps, divides, multiplies and result word.
module bmc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  bmc_pkg::dp_status_t status,
    output bmc_pkg::dp_cmd_t    cmd
);
    import bmc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_FILT     = 6'b000010,
        ST_DIV_GO   = 6'b000100,
        ST_DIV_WAIT = 6'b001000,
        ST_MUL      = 6'b010000,
        ST_MIX      = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] div_idx_reg, div_idx_next;
    logic [2:0] mul_idx_reg, mul_idx_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd          = '0;
        cmd.div_sel  = div_sel_t'(div_idx_reg);
        cmd.mul_sel  = mul_sel_t'(mul_idx_reg);
        cmd.acc_sel  = mul_sel_t'(mul_idx_reg - 3'd1);
        state_next   = state_reg;
        div_idx_next = div_idx_reg;
        mul_idx_next = mul_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready     = state_reg == ST_IDLE;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load     = 1'b1;
                    div_idx_next = DS_MOVE;
                    mul_idx_next = '0;
                    state_next   = ST_FILT;
                end
            end
            ST_FILT:
            begin
                cmd.filt_abs   = mul_idx_reg == 3'd0;
                cmd.filt_mul   = mul_idx_reg == 3'd1;
                cmd.filt_store = mul_idx_reg == 3'd2;
                mul_idx_next   = mul_idx_reg + 3'd1;
                if (mul_idx_reg == 3'd2)
                begin
                    mul_idx_next = '0;
                    state_next   = ST_DIV_GO;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    div_idx_next  = div_idx_reg + 2'd1;
                    if (div_idx_reg == 2'd3)
                    begin
                        mul_idx_next = '0;
                        state_next   = ST_MUL;
                    end
                    else
                        state_next = ST_DIV_GO;
                end
            end
            ST_MUL:
            begin
                cmd.mul_en   = mul_idx_reg < 3'(MUL_STEPS);
                cmd.acc_en   = mul_idx_reg != 3'd0;
                cmd.upd      = mul_idx_reg == 3'd0;
                mul_idx_next = mul_idx_reg + 3'd1;
                if (mul_idx_reg == 3'(MUL_STEPS))
                    state_next = ST_MIX;
            end
            ST_MIX:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.fin        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_idx_reg   <= '0;
            mul_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_idx_reg   <= div_idx_next;
            mul_idx_reg   <= mul_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== sv/balance_robot_motor_controller_core.sv =====
// Top level of the two-wheel balance motor controller.
// Sequence from the accepting edge to a valid result word: the filter steps (absolute value,
// multiply, store), three passes through the shared 27-bit divider, six multiply steps, one mix.
// Flow: a new word is taken only once the last is in the output register, and a finished word
// waits in the mix step while the previous result is unread.
// Reset: rst_n asynchronous, active low; loop state cleared, registers to defaults.
module balance_robot_motor_controller_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [bmc_pkg::IDX_W-1:0] cfg_index,
    input  logic [bmc_pkg::CFG_W-1:0] cfg_data,
    bmc_in_if.sink                    in_word,
    bmc_out_if.source                 out_word
);
    import bmc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    bmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_word.valid),
        .in_ready  (in_word.ready),
        .out_valid (out_word.valid),
        .out_ready (out_word.ready),
        .status    (status),
        .cmd       (cmd)
    );

    bmc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .tilt_angle     (in_word.tilt_angle),
        .pitch_rate     (in_word.pitch_rate),
        .yaw_rate       (in_word.yaw_rate),
        .left_count     (in_word.left_count),
        .right_count    (in_word.right_count),
        .go_forward     (in_word.go_forward),
        .go_backward    (in_word.go_backward),
        .go_left        (in_word.go_left),
        .go_right       (in_word.go_right),
        .stop_request   (in_word.stop_request),
        .cmd            (cmd),
        .status         (status),
        .motor_a_drive  (out_word.motor_a_drive),
        .motor_b_drive  (out_word.motor_b_drive),
        .motors_enabled (out_word.motors_enabled)
    );

endmodule

// ===== tb/tb_balance_robot_motor_controller_core.sv =====
// Testbench for the balance motor controller core: scoreboard with a loop predictor and random ticks.
`timescale 1ns / 1ps

module tb_balance_robot_motor_controller_core;
    import bmc_pkg::*;

    typedef struct {
        logic signed [16:0] tilt;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic signed [15:0] left_cnt;
        logic signed [15:0] right_cnt;
        logic               fwd;
        logic               bwd;
        logic               lft;
        logic               rgt;
        logic               stop;
    } tick_t;

    typedef struct {
        logic signed [13:0] drive_a;
        logic signed [13:0] drive_b;
        logic               enabled;
    } drive_t;

    class drive_scoreboard;
        logic signed [14:0] mid_angle;
        logic signed [20:0] bal_kp, bal_kd, vel_kp, vel_ki, trn_kp;
        logic [7:0]         speed_div;
        logic [12:0]        pwm_lim;
        longint             filt_speed, speed_int, turn_tgt, turn_start;
        bit                 turning;
        drive_t             expected_drives[$];
        int                 mismatches;

        function new();
            mid_angle  = MID_ANGLE_RST;
            bal_kp     = BALANCE_KP_RST;
            bal_kd     = BALANCE_KD_RST;
            vel_kp     = VELOCITY_KP_RST;
            vel_ki     = VELOCITY_KI_RST;
            trn_kp     = TURN_KP_RST;
            speed_div  = SPEED_DIV_RST;
            pwm_lim    = PWM_LIMIT_RST;
            filt_speed = 0;
            speed_int  = 0;
            turn_tgt   = 0;
            turn_start = 0;
            turning    = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [20:0] v);
            case (idx)
                CR_MID_ANGLE:   mid_angle = v[14:0];
                CR_BALANCE_KP:  bal_kp    = v;
                CR_BALANCE_KD:  bal_kd    = v;
                CR_VELOCITY_KP: vel_kp    = v;
                CR_VELOCITY_KI: vel_ki    = v;
                CR_TURN_KP:     trn_kp    = v;
                CR_SPEED_DIV:   speed_div = v[7:0];
                CR_PWM_LIMIT:   pwm_lim   = v[12:0];
                default: ;
            endcase
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return (v < lo) ? lo : ((v > hi) ? hi : v);
        endfunction

        function void note_tick(tick_t t);
            longint dv, lim, bal, vel, trn, mv, sum, step, amp, m1, m2;
            bit     off;
            drive_t d;
            dv  = (speed_div == 0) ? 1 : longint'(speed_div);
            lim = longint'(pwm_lim);
            off = (t.tilt < -10240) || (t.tilt > 10240) || t.stop;
            bal = (longint'(bal_kp) * (longint'(t.tilt) - longint'(mid_angle))
                   + longint'(bal_kd) * longint'(t.pitch) * 256) / 65536;
            if (t.fwd)
                mv = 300 / dv;
            else if (t.bwd)
                mv = -(250 / dv);
            else
                mv = 0;
            sum = longint'(t.left_cnt) + longint'(t.right_cnt);
            filt_speed = (sum * 64 + 9 * filt_speed) / 10;
            speed_int = clip(speed_int + filt_speed - mv * 64, -640000, 640000);
            vel = (filt_speed * longint'(vel_kp) + speed_int * longint'(vel_ki)) / 16384;
            if (off)
                speed_int = 0;
            if (t.lft || t.rgt)
            begin
                if (!turning)
                begin
                    turning    = 1;
                    turn_start = (sum < 0) ? -sum : sum;
                end
                step = (turn_start == 0) ? 768 : 12800 / turn_start;
                step = clip(step, 154, 768);
            end
            else
            begin
                step       = 230;
                turning    = 0;
                turn_start = 0;
            end
            if (t.lft)
                turn_tgt -= step;
            else if (t.rgt)
                turn_tgt += step;
            else
                turn_tgt = 0;
            amp = (150 / dv) * 256;
            turn_tgt = clip(turn_tgt, -amp, amp);
            trn = -turn_tgt * longint'(trn_kp);
            if (t.fwd || t.bwd)
                trn -= longint'(t.yaw) * 65536;
            trn /= 65536;
            m1 = clip(bal - vel - trn, -lim, lim);
            m2 = clip(bal - vel + trn, -lim, lim);
            d.drive_a = off ? 14'sd0 : m1[13:0];
            d.drive_b = off ? 14'sd0 : m2[13:0];
            d.enabled = !off;
            expected_drives.push_back(d);
        endfunction

        function void check_drive(drive_t got);
            drive_t exp_d;
            if (expected_drives.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: a=%0d b=%0d en=%0b",
                             got.drive_a, got.drive_b, got.enabled);
                return;
            end
            exp_d = expected_drives.pop_front();
            if (exp_d.drive_a !== got.drive_a || exp_d.drive_b !== got.drive_b
                || exp_d.enabled !== got.enabled)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp a=%0d b=%0d en=%0b, got a=%0d b=%0d en=%0b",
                             exp_d.drive_a, exp_d.drive_b, exp_d.enabled,
                             got.drive_a, got.drive_b, got.enabled);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    bmc_in_if             in_word ();
    bmc_out_if            out_word ();

    drive_scoreboard      sb;
    bit                   no_gaps;
    int                   hold_req;
    bit                   cmd_f, cmd_b, cmd_l, cmd_r;

    balance_robot_motor_controller_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (in_word.sink),
        .out_word  (out_word.source)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic write_reg(cfg_reg_t idx, longint v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v[CFG_W-1:0];
        sb.set_reg(idx, v[CFG_W-1:0]);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_tick(tick_t t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            in_word.valid <= 1'b0;
        end
        @(negedge clk);
        in_word.valid        <= 1'b1;
        in_word.tilt_angle   <= t.tilt;
        in_word.pitch_rate   <= t.pitch;
        in_word.yaw_rate     <= t.yaw;
        in_word.left_count   <= t.left_cnt;
        in_word.right_count  <= t.right_cnt;
        in_word.go_forward   <= t.fwd;
        in_word.go_backward  <= t.bwd;
        in_word.go_left      <= t.lft;
        in_word.go_right     <= t.rgt;
        in_word.stop_request <= t.stop;
        do
            @(posedge clk);
        while (in_word.ready !== 1'b1);
        sb.note_tick(t);
    endtask

    task automatic settle();
        @(negedge clk);
        in_word.valid <= 1'b0;
        while (sb.expected_drives.size() != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
    endtask

    function automatic tick_t mk_tick(int tilt, int pitch, int yaw, int lc, int rc,
                                      bit f, bit b, bit l, bit r, bit s);
        tick_t t;
        t.tilt = 17'(tilt); t.pitch = 16'(pitch); t.yaw = 16'(yaw);
        t.left_cnt = 16'(lc); t.right_cnt = 16'(rc);
        t.fwd = f; t.bwd = b; t.lft = l; t.rgt = r; t.stop = s;
        return t;
    endfunction

    function automatic int srand(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        if ($urandom_range(0, 7) == 0)
            return mk_tick(srand(46080), srand(32767) - $urandom_range(0, 1), srand(32767),
                           srand(32767) - $urandom_range(0, 1), srand(32767),
                           $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
        begin
            cmd_f = 0; cmd_b = 0; cmd_l = 0; cmd_r = 0;
            case ($urandom_range(0, 5))
                0: cmd_f = 1;
                1: cmd_b = 1;
                2: cmd_l = 1;
                3: cmd_r = 1;
                4: begin cmd_f = 1; cmd_l = $urandom_range(0, 1); cmd_r = !cmd_l; end
                default: ;
            endcase
        end
        t = mk_tick(srand(11000), srand(3000), srand(3000), srand(120), srand(120),
                    cmd_f, cmd_b, cmd_l, cmd_r, $urandom_range(0, 29) == 0);
        if ($urandom_range(0, 5) == 0)
            t.left_cnt = '0;
        if ($urandom_range(0, 5) == 0)
            t.right_cnt = -t.left_cnt;
        return t;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
        begin
            if (i % 50 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_tick(rand_tick());
        end
        no_gaps = 0;
    endtask

    task automatic random_config();
        write_reg(CR_MID_ANGLE,   srand(11520));
        write_reg(CR_BALANCE_KP,  srand(1048575));
        write_reg(CR_BALANCE_KD,  srand(1048575));
        write_reg(CR_VELOCITY_KP, srand(1048575));
        write_reg(CR_VELOCITY_KI, srand(1048575));
        write_reg(CR_TURN_KP,     srand(1048575));
        write_reg(CR_SPEED_DIV,   $urandom_range(1, 255));
        write_reg(CR_PWM_LIMIT,   $urandom_range(0, 8191));
    endtask

    task automatic fixed_config(longint mid, longint gain, longint dv, longint lim);
        write_reg(CR_MID_ANGLE,   mid);
        write_reg(CR_BALANCE_KP,  gain);
        write_reg(CR_BALANCE_KD,  gain);
        write_reg(CR_VELOCITY_KP, gain);
        write_reg(CR_VELOCITY_KI, gain);
        write_reg(CR_TURN_KP,     gain);
        write_reg(CR_SPEED_DIV,   dv);
        write_reg(CR_PWM_LIMIT,   lim);
    endtask

    initial
    begin
        forever
        begin
            int w;
            drive_t d;
            w = no_gaps ? 0 : $urandom_range(0, 11);
            if (hold_req > 0)
            begin
                w = hold_req;
                hold_req = 0;
            end
            repeat (w)
            begin
                @(negedge clk);
                out_word.ready <= 1'b0;
            end
            @(negedge clk);
            out_word.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_word.valid !== 1'b1);
            d.drive_a = out_word.motor_a_drive;
            d.drive_b = out_word.motor_b_drive;
            d.enabled = out_word.motors_enabled;
            sb.check_drive(d);
        end
    end

    initial
    begin
        sb = new();
        no_gaps = 0;
        hold_req = 0;
        cmd_f = 0; cmd_b = 0; cmd_l = 0; cmd_r = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_word.valid = 1'b0;
        in_word.tilt_angle = '0;
        in_word.pitch_rate = '0;
        in_word.yaw_rate = '0;
        in_word.left_count = '0;
        in_word.right_count = '0;
        in_word.go_forward = 1'b0;
        in_word.go_backward = 1'b0;
        in_word.go_left = 1'b0;
        in_word.go_right = 1'b0;
        in_word.stop_request = 1'b0;
        out_word.ready = 1'b0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: tilt limits, stop, each command, zero start speed, field extremes
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_tick(mk_tick(10240, 100, 0, 5, 5, 0, 0, 0, 0, 0));
        send_tick(mk_tick(-10240, -100, 0, -5, -5, 0, 0, 0, 0, 0));
        send_tick(mk_tick(10241, 0, 0, 3, 3, 0, 0, 0, 0, 0));
        send_tick(mk_tick(-10241, 0, 0, 3, 3, 0, 0, 0, 0, 0));
        send_tick(mk_tick(46080, 32767, 32767, 32767, 32767, 1, 0, 0, 0, 0));
        send_tick(mk_tick(-46080, -32768, -32768, -32768, -32768, 0, 1, 0, 0, 0));
        send_tick(mk_tick(200, 0, 0, 10, 10, 0, 0, 0, 0, 1));
        send_tick(mk_tick(300, 50, 20, 10, 12, 1, 0, 0, 0, 0));
        send_tick(mk_tick(300, 50, -20, 10, 12, 1, 0, 0, 0, 0));
        send_tick(mk_tick(-300, -50, 40, -8, -9, 0, 1, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        send_tick(mk_tick(0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
        send_tick(mk_tick(0, 0, 0, 30, 30, 0, 0, 0, 1, 0));
        send_tick(mk_tick(0, 0, 0, 40, 40, 0, 0, 0, 0, 0));
        send_tick(mk_tick(0, 0, 0, 100, 100, 0, 0, 0, 1, 0));
        send_tick(mk_tick(0, 0, 0, 1, 1, 0, 0, 0, 0, 0));
        send_tick(mk_tick(100, 10, 500, 2, 3, 1, 0, 1, 1, 0));
        send_tick(mk_tick(100, 10, 500, 2, 3, 1, 0, 1, 1, 0));
        send_tick(mk_tick(-11000, 0, 0, 4, 4, 0, 0, 0, 0, 0));
        send_tick(mk_tick(5000, 32767, 32767, 32767, -32768, 0, 0, 0, 0, 0));
        run_random(200);
        settle();

        random_config();
        hold_req = 600;
        run_random(130);
        settle();

        fixed_config(11520, 1048575, 255, 0);
        run_random(100);
        settle();

        fixed_config(-11520, -1048576, 0, 8191);
        run_random(100);
        settle();

        random_config();
        run_random(60);
        @(negedge clk);
        in_word.valid <= 1'b0;
        while (sb.expected_drives.size() != 0)
            @(posedge clk);
        run_random(70);
        settle();

        random_config();
        write_reg(CR_SPEED_DIV, 1);
        write_reg(CR_PWM_LIMIT, 8191);
        run_random(120);
        settle();

        if (sb.mismatches == 0 && sb.expected_drives.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
